// ===== design/mtpbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpbt_pkg: shared types and codes for the mouse to pad button tapper
// Mode codes, register indexes, tap directions and the packed item layouts.
// ----------------------------------------------------------------------------
package mtpbt_pkg;

    localparam int TIME_W = 48;
    localparam int CFG_W  = 16;

    localparam logic [1:0] MODE_DOWN  = 2'd0;
    localparam logic [1:0] MODE_UP    = 2'd1;
    localparam logic [1:0] MODE_WHEEL = 2'd2;
    localparam logic [1:0] MODE_POLL  = 2'd3;

    localparam logic CFG_MIN_PRESS = 1'b0;
    localparam logic CFG_WHEEL_TAP = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [15:0] MIN_PRESS_RESET = 16'd40;
    localparam logic [15:0] WHEEL_TAP_RESET = 16'd50;

    // Input item, the last member in the lowest bits.
    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_ms;
        logic              menu_open;
        logic              wheel_flipped;
        logic signed [15:0] wheel_delta;
        logic [2:0]        button_id;
    } t_item;

    typedef struct packed {
        logic mouse_used;
        logic dpad_down;
        logic dpad_up;
        logic press_b;
        logic press_a;
    } t_result;

endpackage

// ===== design/mouse_to_pad_button_tapper.sv =====
// ----------------------------------------------------------------------------
// mouse_to_pad_button_tapper: mouse buttons and wheel to virtual pad bits
// Tracks held buttons with a minimum press time, accumulates wheel movement
// into pending notches and plays them out as up or down taps on each poll.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                              Contents
// s_axis    in         i_s_tvalid o_s_tready i_s_tdata/tuser  one event or poll
// m_axis    out        o_m_tvalid i_m_tready o_m_tdata       one result per poll
// cfg       in         i_cfg_valid o_cfg_ready index/data     register writes
//
// An item moves from the input register into the state registers, a poll also
// into the result register, so one item is taken every cycle while no poll waits;
// a poll is written to the output register as it leaves the input register.
// A poll waits in the input register only while the output register holds a
// result that is not yet taken; other events never wait.
// Reset is synchronous; state and config take defaults, data registers do not.
module mouse_to_pad_button_tapper #(
    parameter int PENDING_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] button_id, [18:3] wheel_delta, [19] wheel_flipped, [20] menu_open,
    // [68:21] now_ms, [71:69] zero
    input  logic [71:0] i_s_tdata,
    // [1:0] mode
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] press_a, [1] press_b, [2] dpad_up, [3] dpad_down, [4] mouse_used,
    // [7:5] zero
    output logic [7:0]  o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int TW    = mtpbt_pkg::TIME_W;
    localparam int SUM_W = (PENDING_BITS > 10 ? PENDING_BITS : 10) + 1;
    localparam logic signed [SUM_W-1:0] PEND_MAX =
        SUM_W'((64'd1 << (PENDING_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] PEND_MIN = ~PEND_MAX;

    function automatic logic [TW-1:0] add_time(input logic [TW-1:0] now,
                                               input logic [15:0] span);
        logic [TW:0] s;
        s = {1'b0, now} + {{(TW - 15){1'b0}}, span};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    logic [15:0]              r_min_press;
    logic [15:0]              r_wheel_tap;

    mtpbt_pkg::t_item         r_item;
    logic                     r_in_valid;

    logic [1:0]               r_held;
    logic [TW-1:0]            r_press_dl [2];
    logic signed [8:0]        r_frac;
    logic signed [PENDING_BITS-1:0] r_pending;
    logic [1:0]               r_tap_dir;
    logic [TW-1:0]            r_phase_dl;
    logic                     r_tap_pressing;
    logic                     r_used;

    logic                     r_out_valid;
    mtpbt_pkg::t_result       r_out_data;

    logic [1:0]               n_held;
    logic [TW-1:0]            n_press_dl [2];
    logic signed [8:0]        n_frac;
    logic signed [PENDING_BITS-1:0] n_pending;
    logic [1:0]               n_tap_dir;
    logic [TW-1:0]            n_phase_dl;
    logic                     n_tap_pressing;
    logic                     n_used;
    mtpbt_pkg::t_result       n_out_data;

    logic                     w_poll;
    logic                     w_fire;
    logic signed [16:0]       w_delta;
    logic signed [17:0]       w_sum;
    logic signed [17:0]       w_quot;
    logic signed [17:0]       w_rem;
    logic signed [SUM_W-1:0]  w_psum;
    logic [TW-1:0]            w_tap_end;
    logic [TW-1:0]            w_press_end;
    logic                     w_bid;

    assign w_poll      = r_item.mode == mtpbt_pkg::MODE_POLL;
    assign w_fire      = r_in_valid && (!w_poll || !r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {3'b000, r_out_data};

    assign w_tap_end   = add_time(r_item.now_ms, r_wheel_tap);
    assign w_press_end = add_time(r_item.now_ms, r_min_press);
    assign w_bid       = r_item.button_id[0];

    // Wheel: the quotient truncates toward zero, so the remainder keeps the sign.
    always_comb begin
        w_delta = {r_item.wheel_delta[15], r_item.wheel_delta};
        if (r_item.wheel_flipped) begin
            w_delta = -w_delta;
        end
        w_sum  = {{9{r_frac[8]}}, r_frac} + {w_delta[16], w_delta};
        w_quot = (w_sum >>> 8)
               + {17'd0, (w_sum[17] && (w_sum[7:0] != 8'd0))};
        w_rem  = w_sum - {w_quot[9:0], 8'd0};
        w_psum = {{(SUM_W - PENDING_BITS){r_pending[PENDING_BITS-1]}}, r_pending}
               + {{(SUM_W - 10){w_quot[9]}}, w_quot[9:0]};
    end

    always_comb begin
        n_held         = r_held;
        n_press_dl     = r_press_dl;
        n_frac         = r_frac;
        n_pending      = r_pending;
        n_tap_dir      = r_tap_dir;
        n_phase_dl     = r_phase_dl;
        n_tap_pressing = r_tap_pressing;
        n_used         = r_used;
        n_out_data     = r_out_data;
        if (w_poll) begin
            n_out_data.press_a = r_held[0] || (r_item.now_ms < r_press_dl[0]);
            n_out_data.press_b = r_held[1] || (r_item.now_ms < r_press_dl[1]);
            if (r_item.now_ms >= r_phase_dl) begin
                if (r_tap_pressing) begin
                    n_tap_pressing = 1'b0;
                    n_tap_dir      = mtpbt_pkg::DIR_NONE;
                    n_phase_dl     = w_tap_end;
                end else if (r_pending != '0) begin
                    if (!r_pending[PENDING_BITS-1]) begin
                        n_tap_dir = mtpbt_pkg::DIR_UP;
                        n_pending = r_pending - PENDING_BITS'(1);
                    end else begin
                        n_tap_dir = mtpbt_pkg::DIR_DOWN;
                        n_pending = r_pending + PENDING_BITS'(1);
                    end
                    n_tap_pressing = 1'b1;
                    n_phase_dl     = w_tap_end;
                end
            end
            n_out_data.dpad_up    = n_tap_pressing && (n_tap_dir == mtpbt_pkg::DIR_UP);
            n_out_data.dpad_down  = n_tap_pressing && (n_tap_dir != mtpbt_pkg::DIR_UP);
            n_out_data.mouse_used = r_used;
        end else if (!r_item.menu_open) begin
            if (r_item.mode == mtpbt_pkg::MODE_WHEEL) begin
                n_frac = w_rem[8:0];
                if (w_psum > PEND_MAX) begin
                    n_pending = PEND_MAX[PENDING_BITS-1:0];
                end else if (w_psum < PEND_MIN) begin
                    n_pending = PEND_MIN[PENDING_BITS-1:0];
                end else begin
                    n_pending = w_psum[PENDING_BITS-1:0];
                end
                n_used = 1'b1;
            end else if (r_item.button_id[2:1] == 2'b00) begin
                n_used = 1'b1;
                if (r_item.mode == mtpbt_pkg::MODE_DOWN) begin
                    n_held[w_bid]     = 1'b1;
                    n_press_dl[w_bid] = w_press_end;
                end else begin
                    n_held[w_bid] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_press <= mtpbt_pkg::MIN_PRESS_RESET;
            r_wheel_tap <= mtpbt_pkg::WHEEL_TAP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mtpbt_pkg::CFG_MIN_PRESS) begin
                r_min_press <= i_cfg_data;
            end else begin
                r_wheel_tap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= mtpbt_pkg::t_item'({i_s_tuser, i_s_tdata[68:0]});
        end
        if (w_fire && w_poll) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_held         <= 2'b00;
            r_press_dl[0]  <= '0;
            r_press_dl[1]  <= '0;
            r_frac         <= '0;
            r_pending      <= '0;
            r_tap_dir      <= mtpbt_pkg::DIR_NONE;
            r_phase_dl     <= '0;
            r_tap_pressing <= 1'b0;
            r_used         <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_fire && w_poll) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_held         <= n_held;
                r_press_dl     <= n_press_dl;
                r_frac         <= n_frac;
                r_pending      <= n_pending;
                r_tap_dir      <= n_tap_dir;
                r_phase_dl     <= n_phase_dl;
                r_tap_pressing <= n_tap_pressing;
                r_used         <= n_used;
            end
        end
    end

    a_dir_matches_press : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap_pressing == (r_tap_dir != mtpbt_pkg::DIR_NONE))
        else $error("tap direction does not match the press phase");

    a_frac_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac != 9'sh100)
        else $error("wheel remainder out of range");

    a_poll_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_poll) |=> r_out_valid)
        else $error("poll transfer did not produce a result");

    a_event_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_poll && !r_out_valid) |=> !r_out_valid)
        else $error("event produced a result");

    a_used_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used |=> r_used)
        else $error("used flag cleared outside reset");

endmodule
